// ----- src/mmcal_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmcal_pkg: shared types and constants
// Widths and sequencer states for the magnetometer min/max calibrator.
// ----------------------------------------------------------------------------
package mmcal_pkg;

    localparam int SAMPLE_BITS     = 16;
    localparam int SCALE_FRAC_BITS = 12;
    localparam int SCALE_BITS      = SCALE_FRAC_BITS + 4;
    localparam int AXES            = 3;
    localparam int AXIS_BITS       = 2;
    localparam int RANGE_BITS      = SAMPLE_BITS + 1;
    localparam int RSUM_BITS       = RANGE_BITS + 2;
    localparam int DEN_BITS        = RANGE_BITS + 2;
    localparam int NUM_BITS        = RSUM_BITS + SCALE_FRAC_BITS;
    localparam int REM_BITS        = DEN_BITS + 1;
    localparam int CNT_BITS        = $clog2(SCALE_BITS + 1);
    localparam int DIFF_BITS       = SAMPLE_BITS + 1;
    localparam int MULT_BITS       = DIFF_BITS + SCALE_BITS + 1;
    localparam int Q_BITS          = MULT_BITS - SCALE_FRAC_BITS;
    localparam int TDATA_BITS      = ((AXES * SAMPLE_BITS + 7) / 8) * 8;

    localparam logic [SCALE_BITS-1:0] SCALE_ONE = SCALE_BITS'(1) << SCALE_FRAC_BITS;
    localparam logic [SCALE_BITS-1:0] SCALE_MAX = {SCALE_BITS{1'b1}};

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic [RANGE_BITS-1:0]         range_t;
    typedef logic [SCALE_BITS-1:0]         scale_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RANGE,
        ST_SETUP,
        ST_DIV,
        ST_MUL,
        ST_SAT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                start;
        logic [NUM_BITS-1:0] numer;
        logic [DEN_BITS-1:0] den;
    } div_req_t;

endpackage

// ----- src/mmcal_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmcal_div: restoring divider for the axis scale
// One quotient bit per cycle; the caller guarantees the quotient fits
// in the scale width, so the upper numerator bits start as the remainder.
// ----------------------------------------------------------------------------
module mmcal_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  mmcal_pkg::div_req_t         req,
    output logic                        done,
    output mmcal_pkg::scale_t           quot
);

    logic [mmcal_pkg::REM_BITS-1:0]   rem_reg, rem_next;
    logic [mmcal_pkg::SCALE_BITS-1:0] qw_reg, qw_next;
    logic [mmcal_pkg::CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic                             busy_reg, busy_next;
    logic                             done_reg, done_next;
    logic [mmcal_pkg::REM_BITS-1:0]   trial;
    logic [mmcal_pkg::REM_BITS-1:0]   den_ext;

    always_comb begin
        den_ext   = {1'b0, req.den};
        trial     = {rem_reg[mmcal_pkg::REM_BITS-2:0], qw_reg[mmcal_pkg::SCALE_BITS-1]};
        rem_next  = rem_reg;
        qw_next   = qw_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next  = mmcal_pkg::REM_BITS'(req.numer >> mmcal_pkg::SCALE_BITS);
            qw_next   = req.numer[mmcal_pkg::SCALE_BITS-1:0];
            cnt_next  = mmcal_pkg::CNT_BITS'(mmcal_pkg::SCALE_BITS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= den_ext) begin
                rem_next = trial - den_ext;
                qw_next  = {qw_reg[mmcal_pkg::SCALE_BITS-2:0], 1'b1};
            end else begin
                rem_next = trial;
                qw_next  = {qw_reg[mmcal_pkg::SCALE_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - mmcal_pkg::CNT_BITS'(1);
            if (cnt_reg == mmcal_pkg::CNT_BITS'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        qw_reg  <= qw_next;
    end

    assign done = done_reg;
    assign quot = qw_reg;

endmodule

// ----- src/magnetometer_minmax_calibrator_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magnetometer_minmax_calibrator_core: min/max hard/soft iron correction
// Sequence from input transaction to m_tvalid: a range state, then per axis a
// setup state, the shared serial divider, a multiply and a saturate, then the
// output register. An axis with zero range or saturated scale skips the divider.
// A new sample is taken only in the idle state, after the last result has entered
// the output register, which waits while an earlier result is still held there.
// Reset (aresetn low, synchronous) clears the bounds to zero and the handshakes.
// ----------------------------------------------------------------------------
module magnetometer_minmax_calibrator_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [mmcal_pkg::TDATA_BITS-1:0]   s_tdata,  // mag_x, mag_y, mag_z
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [mmcal_pkg::TDATA_BITS-1:0]   m_tdata,  // cal_x, cal_y, cal_z
    output logic [0:0]                         m_tuser   // clipped
);

    localparam int SB = mmcal_pkg::SAMPLE_BITS;

    mmcal_pkg::state_t  state_reg, state_next;
    logic [mmcal_pkg::AXIS_BITS-1:0] ax_reg, ax_next;

    mmcal_pkg::sample_t upper_reg [mmcal_pkg::AXES];
    mmcal_pkg::sample_t upper_next [mmcal_pkg::AXES];
    mmcal_pkg::sample_t lower_reg [mmcal_pkg::AXES];
    mmcal_pkg::sample_t lower_next [mmcal_pkg::AXES];
    mmcal_pkg::sample_t samp_reg [mmcal_pkg::AXES];
    mmcal_pkg::sample_t samp_next [mmcal_pkg::AXES];
    mmcal_pkg::sample_t cal_reg [mmcal_pkg::AXES];
    mmcal_pkg::sample_t cal_next [mmcal_pkg::AXES];
    mmcal_pkg::range_t  range_reg [mmcal_pkg::AXES];
    mmcal_pkg::range_t  range_next [mmcal_pkg::AXES];

    logic [mmcal_pkg::RSUM_BITS-1:0]   rsum_reg, rsum_next;
    mmcal_pkg::scale_t                 scale_reg, scale_next;
    logic signed [mmcal_pkg::DIFF_BITS-1:0] diff_reg, diff_next;
    logic signed [mmcal_pkg::MULT_BITS-1:0] prod_reg, prod_next;
    logic                              clip_reg, clip_next;

    logic                              m_valid_reg, m_valid_next;
    logic [mmcal_pkg::TDATA_BITS-1:0]  m_data_reg, m_data_next;
    logic                              m_clip_reg, m_clip_next;

    mmcal_pkg::div_req_t               div_req;
    logic                              div_done;
    mmcal_pkg::scale_t                 div_quot;

    logic                              s_accept;
    logic [mmcal_pkg::DEN_BITS-1:0]    den;
    logic [mmcal_pkg::DEN_BITS+3:0]    den_x16;
    logic [mmcal_pkg::DEN_BITS+3:0]    rsum_ext;
    logic signed [SB:0]                bsum;
    logic signed [mmcal_pkg::DIFF_BITS-1:0] mid_ext;
    logic signed [mmcal_pkg::MULT_BITS-1:0] adj;
    logic signed [mmcal_pkg::Q_BITS-1:0]    qv;
    logic [mmcal_pkg::Q_BITS-SB:0]     qhi;
    mmcal_pkg::range_t                 r_cur;

    assign s_tready = aresetn && (state_reg == mmcal_pkg::ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    mmcal_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .done    (div_done),
        .quot    (div_quot)
    );

    always_comb begin
        state_next   = state_reg;
        ax_next      = ax_reg;
        upper_next   = upper_reg;
        lower_next   = lower_reg;
        samp_next    = samp_reg;
        cal_next     = cal_reg;
        range_next   = range_reg;
        rsum_next    = rsum_reg;
        scale_next   = scale_reg;
        diff_next    = diff_reg;
        prod_next    = prod_reg;
        clip_next    = clip_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_clip_next  = m_clip_reg;

        r_cur    = range_reg[ax_reg];
        den      = mmcal_pkg::DEN_BITS'({r_cur, 1'b0}) + mmcal_pkg::DEN_BITS'(r_cur);
        den_x16  = {den, 4'b0000};
        rsum_ext = (mmcal_pkg::DEN_BITS + 4)'(rsum_reg);
        bsum     = {upper_reg[ax_reg][SB-1], upper_reg[ax_reg]}
                 + {lower_reg[ax_reg][SB-1], lower_reg[ax_reg]};
        mid_ext  = {bsum[SB], bsum[SB:1]};

        adj = prod_reg + $signed({{(mmcal_pkg::MULT_BITS - mmcal_pkg::SCALE_FRAC_BITS){1'b0}},
                                  {mmcal_pkg::SCALE_FRAC_BITS{prod_reg[mmcal_pkg::MULT_BITS-1]}}});
        qv  = adj[mmcal_pkg::MULT_BITS-1:mmcal_pkg::SCALE_FRAC_BITS];
        qhi = qv[mmcal_pkg::Q_BITS-1:SB-1];

        div_req.start = 1'b0;
        div_req.numer = {rsum_reg, {mmcal_pkg::SCALE_FRAC_BITS{1'b0}}};
        div_req.den   = den;

        case (state_reg)
            mmcal_pkg::ST_IDLE: begin
                if (s_accept) begin
                    for (int a = 0; a < mmcal_pkg::AXES; a++) begin
                        samp_next[a] = s_tdata[a*SB +: SB];
                        if ($signed(s_tdata[a*SB +: SB]) >= upper_reg[a]) begin
                            upper_next[a] = s_tdata[a*SB +: SB];
                        end else if ($signed(s_tdata[a*SB +: SB]) <= lower_reg[a]) begin
                            lower_next[a] = s_tdata[a*SB +: SB];
                        end
                    end
                    clip_next  = 1'b0;
                    ax_next    = '0;
                    state_next = mmcal_pkg::ST_RANGE;
                end
            end
            mmcal_pkg::ST_RANGE: begin
                for (int a = 0; a < mmcal_pkg::AXES; a++) begin
                    range_next[a] = mmcal_pkg::RANGE_BITS'({upper_reg[a][SB-1], upper_reg[a]}
                                  - {lower_reg[a][SB-1], lower_reg[a]});
                end
                rsum_next  = mmcal_pkg::RSUM_BITS'(range_next[0])
                           + mmcal_pkg::RSUM_BITS'(range_next[1])
                           + mmcal_pkg::RSUM_BITS'(range_next[2]);
                state_next = mmcal_pkg::ST_SETUP;
            end
            mmcal_pkg::ST_SETUP: begin
                diff_next = {samp_reg[ax_reg][SB-1], samp_reg[ax_reg]} - mid_ext;
                if (r_cur == '0) begin
                    scale_next = mmcal_pkg::SCALE_ONE;
                    state_next = mmcal_pkg::ST_MUL;
                end else if (rsum_ext >= den_x16) begin
                    scale_next = mmcal_pkg::SCALE_MAX;
                    clip_next  = 1'b1;
                    state_next = mmcal_pkg::ST_MUL;
                end else begin
                    div_req.start = 1'b1;
                    state_next    = mmcal_pkg::ST_DIV;
                end
            end
            mmcal_pkg::ST_DIV: begin
                if (div_done) begin
                    scale_next = div_quot;
                    state_next = mmcal_pkg::ST_MUL;
                end
            end
            mmcal_pkg::ST_MUL: begin
                prod_next  = mmcal_pkg::MULT_BITS'(diff_reg)
                           * mmcal_pkg::MULT_BITS'($signed({1'b0, scale_reg}));
                state_next = mmcal_pkg::ST_SAT;
            end
            mmcal_pkg::ST_SAT: begin
                if ((qhi == '0) || (qhi == '1)) begin
                    cal_next[ax_reg] = qv[SB-1:0];
                end else if (qv[mmcal_pkg::Q_BITS-1]) begin
                    cal_next[ax_reg] = {1'b1, {(SB-1){1'b0}}};
                    clip_next        = 1'b1;
                end else begin
                    cal_next[ax_reg] = {1'b0, {(SB-1){1'b1}}};
                    clip_next        = 1'b1;
                end
                if (ax_reg == mmcal_pkg::AXIS_BITS'(mmcal_pkg::AXES - 1)) begin
                    state_next = mmcal_pkg::ST_DONE;
                end else begin
                    ax_next    = ax_reg + mmcal_pkg::AXIS_BITS'(1);
                    state_next = mmcal_pkg::ST_SETUP;
                end
            end
            mmcal_pkg::ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = mmcal_pkg::TDATA_BITS'({cal_reg[2], cal_reg[1], cal_reg[0]});
                    m_clip_next  = clip_reg;
                    state_next   = mmcal_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mmcal_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mmcal_pkg::ST_IDLE;
            ax_reg      <= '0;
            m_valid_reg <= 1'b0;
            for (int a = 0; a < mmcal_pkg::AXES; a++) begin
                upper_reg[a] <= '0;
                lower_reg[a] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            ax_reg      <= ax_next;
            m_valid_reg <= m_valid_next;
            upper_reg   <= upper_next;
            lower_reg   <= lower_next;
        end
        samp_reg   <= samp_next;
        cal_reg    <= cal_next;
        range_reg  <= range_next;
        rsum_reg   <= rsum_next;
        scale_reg  <= scale_next;
        diff_reg   <= diff_next;
        prod_reg   <= prod_next;
        clip_reg   <= clip_next;
        m_data_reg <= m_data_next;
        m_clip_reg <= m_clip_next;
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_clip_reg;

endmodule

// ----- tb/tb_magnetometer_minmax_calibrator_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_magnetometer_minmax_calibrator_core: self-checking stream testbench
// Feeds three-axis samples into the calibrator and keeps its own running
// per-axis min/max to predict each corrected sample and clip flag. Every
// output transaction is compared field by field with the oldest prediction.
// A short directed table comes first. Random samples follow inside per-axis
// envelopes that widen slowly toward full scale. The input side is bursty,
// the output side stalls in changing patterns, and it holds off once long
// enough to back up the input.
// ----------------------------------------------------------------------------
module tb_magnetometer_minmax_calibrator_core;
    import mmcal_pkg::*;

    localparam int     RESET_CYCLES     = 12;
    localparam int     DIRECTED_ROWS    = 13;
    localparam int     RANDOM_ITEMS     = 1800;
    localparam int     FULL_SCALE_ITEMS = 300;
    localparam int     HOLD_AFTER       = 400;
    localparam int     HOLD_CYCLES      = 600;
    localparam int     DRAIN_CYCLES     = 128;
    localparam int     CYCLE_LIMIT      = 1000000;
    localparam longint CAL_MAX          = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    localparam longint CAL_MIN          = -CAL_MAX - 1;
    localparam longint SCALE_DIV        = longint'(1) << SCALE_FRAC_BITS;

    typedef struct packed {
        logic                        clipped;
        logic [AXES*SAMPLE_BITS-1:0] cal;      // cal_x, cal_y, cal_z
    } correction_t;

    typedef struct packed {
        logic                  typed;
        logic [TDATA_BITS-1:0] raw;            // mag_x, mag_y, mag_z
        correction_t           want;
    } directed_row_t;

    typedef enum int {
        READY_ALWAYS,
        READY_HALF,
        READY_SPARSE
    } ready_mode_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [TDATA_BITS-1:0] s_tdata;   // mag_x, mag_y, mag_z
    logic                  m_tvalid;
    logic                  m_tready;
    logic [TDATA_BITS-1:0] m_tdata;   // cal_x, cal_y, cal_z
    logic [0:0]            m_tuser;   // clipped

    longint        axis_max [AXES] = '{default: 0};
    longint        axis_min [AXES] = '{default: 0};
    correction_t   calibrated_q [$];
    int            samples_accepted = 0;
    int            mismatches       = 0;
    int            cycle_count      = 0;
    int            burst_left       = 0;
    logic          offer_typed      = 1'b0;
    correction_t   offer_want       = '0;
    directed_row_t directed_rows [DIRECTED_ROWS];
    string         axis_names [AXES] = '{"cal_x", "cal_y", "cal_z"};

    magnetometer_minmax_calibrator_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [TDATA_BITS-1:0] axes_word(input longint x, input longint y,
                                                        input longint z);
        return TDATA_BITS'({sample_t'(z), sample_t'(y), sample_t'(x)});
    endfunction

    // updates the running bounds, then corrects the sample against them
    function automatic correction_t calibrate_sample(input logic [TDATA_BITS-1:0] raw);
        correction_t res;
        longint      s [AXES];
        longint      span [AXES];
        longint      span_sum;
        longint      scale;
        longint      mid;
        longint      q;
        int          a;
        res = '0;
        span_sum = 0;
        for (a = 0; a < AXES; a++) begin
            s[a] = longint'(sample_t'(raw[a*SAMPLE_BITS +: SAMPLE_BITS]));
            if (s[a] >= axis_max[a]) begin
                axis_max[a] = s[a];
            end else if (s[a] <= axis_min[a]) begin
                axis_min[a] = s[a];
            end
            span[a] = axis_max[a] - axis_min[a];
            span_sum += span[a];
        end
        for (a = 0; a < AXES; a++) begin
            if (span[a] == 0) begin
                scale = longint'(SCALE_ONE);
            end else begin
                scale = (span_sum << SCALE_FRAC_BITS) / (3 * span[a]);
                if (scale > longint'(SCALE_MAX)) begin
                    scale = longint'(SCALE_MAX);
                    res.clipped = 1'b1;
                end
            end
            mid = (axis_max[a] + axis_min[a]) >>> 1;
            q = (s[a] - mid) * scale / SCALE_DIV;
            if (q > CAL_MAX) begin
                q = CAL_MAX;
                res.clipped = 1'b1;
            end else if (q < CAL_MIN) begin
                q = CAL_MIN;
                res.clipped = 1'b1;
            end
            res.cal[a*SAMPLE_BITS +: SAMPLE_BITS] = q[SAMPLE_BITS-1:0];
        end
        return res;
    endfunction

    task automatic offer_sample(input logic [TDATA_BITS-1:0] raw, input logic typed,
                                input correction_t want);
        int gap;
        gap = 0;
        @(negedge aclk);
        if (burst_left == 0) begin
            burst_left = ($urandom_range(9, 0) == 0) ? $urandom_range(200, 50)
                                                     : $urandom_range(16, 1);
            gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata <= raw;
        s_tvalid <= 1'b1;
        offer_typed = typed;
        offer_want = want;
        do @(posedge aclk); while (!s_tready);
        burst_left--;
    endtask

    // output check first, then the prediction for an input accepted on the same edge
    always @(posedge aclk) begin
        correction_t got;
        correction_t want;
        correction_t predicted;
        int          a;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = '{m_tuser[0], m_tdata[AXES*SAMPLE_BITS-1:0]};
                if (calibrated_q.size() == 0) begin
                    $error("result transaction with no prediction pending");
                    mismatches++;
                end else begin
                    want = calibrated_q.pop_front();
                    for (a = 0; a < AXES; a++) begin
                        if (got.cal[a*SAMPLE_BITS +: SAMPLE_BITS] !==
                            want.cal[a*SAMPLE_BITS +: SAMPLE_BITS]) begin
                            $error("%s expected %0d actual %0d", axis_names[a],
                                   $signed(want.cal[a*SAMPLE_BITS +: SAMPLE_BITS]),
                                   $signed(got.cal[a*SAMPLE_BITS +: SAMPLE_BITS]));
                            mismatches++;
                        end
                    end
                    if (got.clipped !== want.clipped) begin
                        $error("clipped expected %0d actual %0d", want.clipped, got.clipped);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                predicted = calibrate_sample(s_tdata);
                calibrated_q.push_back(offer_typed ? offer_want : predicted);
                samples_accepted++;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        ready_mode_t mode;
        int          left;
        logic        held;
        m_tready = 1'b0;
        held = 1'b0;
        mode = READY_ALWAYS;
        left = 0;
        forever begin
            @(negedge aclk);
            if (!held && samples_accepted >= HOLD_AFTER) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            if (left == 0) begin
                mode = ready_mode_t'($urandom_range(2, 0));
                left = $urandom_range(300, 40);
            end
            left--;
            case (mode)
                READY_ALWAYS: m_tready <= 1'b1;
                READY_HALF:   m_tready <= 1'($urandom_range(1, 0));
                default:      m_tready <= ($urandom_range(3, 0) == 0);
            endcase
        end
    end

    initial begin
        longint env_hi [AXES];
        longint env_lo [AXES];
        longint grow_step [AXES];
        longint v [AXES];
        int     n;
        int     a;
        int     r;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;

        // zero range, scale saturation on a tiny y span, then mixed rows
        directed_rows[0]  = '{1'b1, axes_word(0, 0, 0), '{1'b0, axes_word(0, 0, 0)}};
        directed_rows[1]  = '{1'b1, axes_word(32767, 0, 0), '{1'b0, axes_word(5460, 0, 0)}};
        directed_rows[2]  = '{1'b1, axes_word(0, 1, 0), '{1'b1, axes_word(-5459, 15, 0)}};
        directed_rows[3]  = '{1'b0, axes_word(0, -1, 0), '0};
        directed_rows[4]  = '{1'b0, axes_word(16383, 0, -32768), '0};
        directed_rows[5]  = '{1'b0, axes_word(-1, -2, 0), '0};
        directed_rows[6]  = '{1'b0, axes_word(-21846, 2, 21845), '0};
        directed_rows[7]  = '{1'b0, axes_word(1, 2, -1), '0};
        directed_rows[8]  = '{1'b0, axes_word(32767, -2, -32768), '0};
        directed_rows[9]  = '{1'b0, axes_word(-16384, 3, 16383), '0};
        directed_rows[10] = '{1'b0, axes_word(100, -3, -100), '0};
        directed_rows[11] = '{1'b0, axes_word(0, 0, 0), '0};
        directed_rows[12] = '{1'b0, axes_word(255, -256, 4095), '0};

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (n = 0; n < DIRECTED_ROWS; n++) begin
            offer_sample(directed_rows[n].raw, directed_rows[n].typed, directed_rows[n].want);
        end

        for (a = 0; a < AXES; a++) begin
            env_hi[a] = 64;
            env_lo[a] = -64;
            grow_step[a] = $urandom_range(400, 16);
        end
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            for (a = 0; a < AXES; a++) begin
                if (n >= RANDOM_ITEMS - FULL_SCALE_ITEMS) begin
                    env_hi[a] = CAL_MAX;
                    env_lo[a] = CAL_MIN;
                end else begin
                    if ($urandom_range(7, 0) == 0) begin
                        env_hi[a] += $urandom_range(int'(grow_step[a]), 0);
                        if (env_hi[a] > CAL_MAX) env_hi[a] = CAL_MAX;
                    end
                    if ($urandom_range(7, 0) == 0) begin
                        env_lo[a] -= $urandom_range(int'(grow_step[a]), 0);
                        if (env_lo[a] < CAL_MIN) env_lo[a] = CAL_MIN;
                    end
                end
                r = $urandom_range(999, 0);
                if (r < 3 && n >= RANDOM_ITEMS / 2) begin
                    v[a] = longint'(sample_t'($urandom));
                end else if (r < 100) begin
                    v[a] = env_hi[a];
                end else if (r < 200) begin
                    v[a] = env_lo[a];
                end else begin
                    v[a] = env_lo[a] + longint'($urandom_range(int'(env_hi[a] - env_lo[a]), 0));
                end
            end
            offer_sample(axes_word(v[0], v[1], v[2]), 1'b0, '0);
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (calibrated_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
